FILE: rtl/wdsk_pkg.sv
// ----------------------------------------------------------------------------
// wdsk_pkg
// Shared constants and types of the weighted degree string kernel.
// ----------------------------------------------------------------------------
package wdsk_pkg;

  localparam int MAX_DEGREE  = 8;
  localparam int SYMBOL_BITS = 8;

  localparam int NUM_WEIGHTS = 8;
  localparam int WEIGHT_W    = 16;
  localparam int SUM_W       = 32;
  localparam int CFG_INDEX_W = 3;

  // run length 0..MAX_DEGREE
  localparam int RUN_W    = $clog2(MAX_DEGREE + 1);
  // sum of up to MAX_DEGREE signed weights
  localparam int PREFIX_W = WEIGHT_W + RUN_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_1 = CFG_INDEX_W'(0);

  // one classified pair: run length ending here (zero on mismatch), end mark
  typedef struct packed {
    logic [RUN_W-1:0] run;
    logic             last;
  } wdsk_item_t;

endpackage

FILE: rtl/wdsk_front.sv
// ----------------------------------------------------------------------------
// wdsk_front
// Accepts symbol pairs, compares them and tracks the current match run.
// ----------------------------------------------------------------------------
module wdsk_front import wdsk_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             left_symbol,
  input  logic [7:0]             right_symbol,
  input  logic                   final_pair,
  input  logic                   q_full,
  output logic                   q_push,
  output wdsk_item_t             q_item
);

  logic [RUN_W-1:0] match_run;
  logic [RUN_W-1:0] match_run_next;
  logic             match;

  assign match = left_symbol[SYMBOL_BITS-1:0] == right_symbol[SYMBOL_BITS-1:0];

  always_comb begin
    if (!match) begin
      match_run_next = '0;
    end else if (match_run == RUN_W'(MAX_DEGREE)) begin
      match_run_next = match_run;
    end else begin
      match_run_next = match_run + RUN_W'(1);
    end
  end

  assign in_ready    = !q_full;
  assign q_push      = in_valid && in_ready;
  assign q_item.run  = match_run_next;
  assign q_item.last = final_pair;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_run <= '0;
    end else if (q_push) begin
      // drop the run at a string end
      match_run <= final_pair ? '0 : match_run_next;
    end
  end

endmodule

FILE: rtl/wdsk_queue.sv
// ----------------------------------------------------------------------------
// wdsk_queue
// Short FIFO of classified pairs between the front and back parts.
// ----------------------------------------------------------------------------
module wdsk_queue import wdsk_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  wdsk_item_t push_item,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output wdsk_item_t head_item
);

  wdsk_item_t            slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_CW-1:0]   count;

  function automatic logic [QUEUE_AW-1:0] advance(input logic [QUEUE_AW-1:0] p);
    logic [QUEUE_AW-1:0] r;
    r = (p == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : p + QUEUE_AW'(1);
    return r;
  endfunction

  assign full       = count == QUEUE_CW'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= advance(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= advance(rd_ptr);
      end
      unique case ({push, pop})
        2'b10:   count <= count + QUEUE_CW'(1);
        2'b01:   count <= count - QUEUE_CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/wdsk_back.sv
// ----------------------------------------------------------------------------
// wdsk_back
// Holds the weights, adds the prefix sum for each run and saturates.
// ----------------------------------------------------------------------------
module wdsk_back import wdsk_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [WEIGHT_W-1:0]    cfg_data,
  input  logic                   head_valid,
  input  wdsk_item_t             head_item,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SUM_W-1:0]       kernel_value,
  output logic                   saturated
);

  logic signed [WEIGHT_W-1:0] weight [NUM_WEIGHTS];
  logic signed [PREFIX_W-1:0] prefix [MAX_DEGREE+1];
  logic [CFG_INDEX_W-1:0]     cfg_slot;
  logic signed [WEIGHT_W:0]   weight_delta;
  logic signed [SUM_W-1:0]    running_sum;
  logic                       clip_flag;
  logic signed [SUM_W:0]      wide_sum;
  logic signed [SUM_W-1:0]    sum_next;
  logic                       clip_next;
  logic                       over;

  assign cfg_slot     = cfg_index - REG_WEIGHT_1;
  assign weight_delta = (WEIGHT_W+1)'($signed(cfg_data)) - (WEIGHT_W+1)'(weight[cfg_slot]);

  assign wide_sum = (SUM_W+1)'(running_sum) + (SUM_W+1)'(prefix[head_item.run]);
  assign over     = wide_sum[SUM_W] != wide_sum[SUM_W-1];

  always_comb begin
    if (!over) begin
      sum_next = wide_sum[SUM_W-1:0];
    end else if (wide_sum[SUM_W]) begin
      sum_next = {1'b1, {(SUM_W-1){1'b0}}};
    end else begin
      sum_next = {1'b0, {(SUM_W-1){1'b1}}};
    end
    clip_next = clip_flag || over;
  end

  // hold a final pair until the output register frees up
  assign pop = head_valid && (!head_item.last || !out_valid || out_ready);

  // prefix[m] = weight_1 + ... + weight_m; a write moves every sum that
  // includes the weight by the change of that weight
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_WEIGHTS; k++) begin
        weight[k] <= '0;
      end
      for (int m = 0; m <= MAX_DEGREE; m++) begin
        prefix[m] <= '0;
      end
    end else if (cfg_we && (32'(cfg_index) < NUM_WEIGHTS)) begin
      weight[cfg_slot] <= cfg_data;
      for (int m = 1; m <= MAX_DEGREE; m++) begin
        if (m > int'(cfg_slot)) begin
          prefix[m] <= prefix[m] + PREFIX_W'(weight_delta);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      clip_flag   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        if (head_item.last) begin
          running_sum <= '0;
          clip_flag   <= 1'b0;
          out_valid   <= 1'b1;
        end else begin
          running_sum <= sum_next;
          clip_flag   <= clip_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_item.last) begin
      kernel_value <= sum_next;
      saturated    <= clip_next;
    end
  end

endmodule

FILE: rtl/weighted_degree_string_kernel.sv
// ----------------------------------------------------------------------------
// weighted_degree_string_kernel
// Weighted degree string kernel over a stream of symbol pairs.
// ----------------------------------------------------------------------------
// Throughput: one symbol pair per cycle, sustained, under no output stall.
// Result path: the final pair passes through the front-to-back queue, then
//   the back loads the output register with the result; a result still
//   waiting there holds the next final pair in the queue.
// Reset: rst clears the run counter, accumulator, clip flag, queue, output
//   valid and all weights to zero; the block takes pairs the cycle after.
// ----------------------------------------------------------------------------
// The front compares each pair and keeps the run of matches ending at it,
// capped at the maximum degree; it ships the run length and end mark into a
// two-entry queue. The back adds the prefix sum of the first run weights to
// the accumulator with saturation, and on the final pair loads the output
// register and clears the accumulator. A waiting result only stalls the back
// at the next final pair; the queue absorbs the front meanwhile.
module weighted_degree_string_kernel import wdsk_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             left_symbol,
  input  logic [7:0]             right_symbol,
  input  logic                   final_pair,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SUM_W-1:0]       kernel_value,
  output logic                   saturated,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [WEIGHT_W-1:0]    cfg_data
);

  logic       q_full;
  logic       q_push;
  logic       q_pop;
  logic       q_head_valid;
  wdsk_item_t q_item;
  wdsk_item_t q_head;

  // classify pairs and track the match run
  wdsk_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .left_symbol  (left_symbol),
    .right_symbol (right_symbol),
    .final_pair   (final_pair),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (q_item)
  );

  // decouple the front from the back
  wdsk_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (q_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_item  (q_head)
  );

  // accumulate, saturate and deliver the result transfer
  wdsk_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .head_valid   (q_head_valid),
    .head_item    (q_head),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kernel_value (kernel_value),
    .saturated    (saturated)
  );

endmodule
